>>> rtl/assert_macros.svh
// Assertion macros used by the RTL core of the S-record line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define SRLP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define SRLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/srlp_pkg.sv
// Types, constants and the hex digit decoder of the S-record line parser.
package srlp_pkg;

  localparam int unsigned MaxLineChars = 255;
  localparam int unsigned LineCntW     = $clog2(MaxLineChars + 1);
  localparam int unsigned LenCmpW      = ((LineCntW > 9) ? LineCntW : 9) + 1;

  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharS  = 8'h53;

  localparam logic [7:0] TypeS0 = 8'h30;
  localparam logic [7:0] TypeS1 = 8'h31;
  localparam logic [7:0] TypeS2 = 8'h32;
  localparam logic [7:0] TypeS3 = 8'h33;
  localparam logic [7:0] TypeS5 = 8'h35;
  localparam logic [7:0] TypeS7 = 8'h37;
  localparam logic [7:0] TypeS8 = 8'h38;
  localparam logic [7:0] TypeS9 = 8'h39;

  localparam logic [8:0] ChecksumGood = 9'h0ff;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindStart  = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    StOk          = 4'd0,
    StNoS         = 4'd1,
    StShort       = 4'd2,
    StLength      = 4'd3,
    StHex         = 4'd4,
    StChecksum    = 4'd5,
    StCount       = 4'd6,
    StS0Addr      = 4'd7,
    StUnsupported = 4'd8,
    StBadType     = 4'd9,
    StS5Count     = 4'd10
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Decodes one hex digit of either case; anything else decodes as zero.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       r;
    logic [7:0] u;
    r = '{ok: 1'b0, value: 4'd0};
    u = c;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = '{ok: 1'b1, value: 4'(c - 8'h30)};
    end else begin
      if (c >= 8'h61 && c <= 8'h7a) begin
        u = c & 8'h5f;
      end
      if (u >= 8'h41 && u <= 8'h46) begin
        r = '{ok: 1'b1, value: 4'(u - 8'h37)};
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/srlp_if.sv
// Handshake channels of the S-record line parser: text characters in, results out.
interface srlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface srlp_result_if;
  import srlp_pkg::*;
  logic        valid;
  logic        ready;
  kind_e       result_kind;
  logic [31:0] byte_address;
  logic [7:0]  data_byte;
  status_e     line_status;

  modport source (output valid, output result_kind, output byte_address,
                  output data_byte, output line_status, input ready);
  modport sink   (input valid, input result_kind, input byte_address,
                  input data_byte, input line_status, output ready);
endinterface

>>> rtl/srecord_line_parser_core.sv
// S-record line parser: checks text lines and streams decoded S3 data and S7 start addresses.
//
// Characters enter on text_i, one per transaction. Carriage returns are dropped, a newline
// closes the line and empty lines are skipped. Results leave on result_o: a data byte with
// its address for each decoded S3 data pair, the start address of an S7 line once its
// fourth address byte is decoded, and a status for every non-empty line. The consumer
// discards the bytes and start address of a line whose status is not zero.
// A character is registered on acceptance and processed once the output register is free
// or being read, when the per-line state is updated and any result is loaded into the
// output register. One character is taken per cycle for as long as the receiver keeps up;
// that figure is set by the single update of the line state per character.
// When the receiver stalls, the output register holds its result and the input register
// holds one more character; only then does text_i drop ready.
// Reset clears the line state, the S3 line total and the halt flag. After the first line
// with a nonzero status the parser halts: characters are still taken but ignored, and no
// result is given until the next reset.
`include "assert_macros.svh"

module srecord_line_parser_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  srlp_char_if.sink            text_i,
  srlp_result_if.source        result_o
);
  import srlp_pkg::*;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_adv;
  logic       in_ready;

  // Line state
  logic [LineCntW-1:0] line_cnt_q, line_cnt_d;
  logic [7:0]          rec_type_q, rec_type_d;
  logic [7:0]          count_q, count_d;
  logic [7:0]          sum_q, sum_d;
  logic [3:0]          hi_nib_q, hi_nib_d;
  logic [7:0]          pair_idx_q, pair_idx_d;
  logic [31:0]         addr_q, addr_d;
  status_e             first_err_q, first_err_d;
  logic [15:0]         s3_total_q, s3_total_d;
  logic                halted_q, halted_d;

  // Output register
  logic        out_valid_q;
  kind_e       out_kind_q, out_kind_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [7:0]  out_data_q, out_data_d;
  status_e     out_status_q, out_status_d;

  // Line status evaluation
  status_e            status_c;
  logic               s3_line_ok_c;
  logic [LenCmpW-1:0] len_minus4;
  logic [LenCmpW-1:0] twice_count;

  logic       emit_c;
  hex_t       hex_c;
  logic [7:0] byte_c;
  logic [2:0] alen_c;
  logic [31:0] addr_acc_c;
  logic       reject_c;
  logic       line_ok_c;

  assign s1_adv   = s1_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign text_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && text_i.valid) begin
      s1_char_q <= text_i.text_char;
    end
  end

  assign len_minus4  = LenCmpW'(line_cnt_q) - LenCmpW'(4);
  assign twice_count = LenCmpW'({count_q, 1'b0});

  // Status of the line held in the state, in order of precedence.
  always_comb begin
    status_c     = StOk;
    s3_line_ok_c = 1'b0;
    if (first_err_q == StNoS) begin
      status_c = StNoS;
    end else if (line_cnt_q < LineCntW'(5)) begin
      status_c = StShort;
    end else if (len_minus4 != twice_count) begin
      status_c = StLength;
    end else if (first_err_q == StHex) begin
      status_c = StHex;
    end else if ({1'b0, sum_q} != ChecksumGood) begin
      status_c = StChecksum;
    end else begin
      case (rec_type_q) inside
        TypeS0: begin
          if (count_q < 8'd3) begin
            status_c = StCount;
          end else if (addr_q[15:0] != 16'd0) begin
            status_c = StS0Addr;
          end
        end
        TypeS1, TypeS9: begin
          status_c = (count_q < 8'd3) ? StCount : StUnsupported;
        end
        TypeS2, TypeS8: begin
          status_c = (count_q < 8'd4) ? StCount : StUnsupported;
        end
        TypeS3: begin
          if (count_q < 8'd5) begin
            status_c = StCount;
          end else begin
            s3_line_ok_c = 1'b1;
          end
        end
        TypeS5: begin
          if (count_q < 8'd3) begin
            status_c = StCount;
          end else if (addr_q[15:0] != s3_total_q) begin
            status_c = StS5Count;
          end
        end
        TypeS7: begin
          status_c = (count_q != 8'd5) ? StCount : StOk;
        end
        default: begin
          status_c = StBadType;
        end
      endcase
    end
  end

  assign hex_c  = hex_decode(s1_char_q);
  assign byte_c = {hi_nib_q, hex_c.value};

  always_comb begin
    case (rec_type_q) inside
      TypeS3, TypeS7: alen_c = 3'd4;
      TypeS0, TypeS5: alen_c = 3'd2;
      default:        alen_c = 3'd0;
    endcase
  end

  // Per-character update of the line state and result selection.
  always_comb begin
    line_cnt_d   = line_cnt_q;
    rec_type_d   = rec_type_q;
    count_d      = count_q;
    sum_d        = sum_q;
    hi_nib_d     = hi_nib_q;
    pair_idx_d   = pair_idx_q;
    addr_d       = addr_q;
    first_err_d  = first_err_q;
    s3_total_d   = s3_total_q;
    halted_d     = halted_q;
    emit_c       = 1'b0;
    out_kind_d   = KindStatus;
    out_addr_d   = 32'd0;
    out_data_d   = 8'd0;
    out_status_d = StOk;
    addr_acc_c   = addr_q;

    if (s1_adv && !halted_q && s1_char_q != CharCr) begin
      if (s1_char_q == CharLf) begin
        line_cnt_d  = '0;
        rec_type_d  = 8'd0;
        count_d     = 8'd0;
        sum_d       = 8'd0;
        hi_nib_d    = 4'd0;
        pair_idx_d  = 8'd0;
        addr_d      = 32'd0;
        first_err_d = StOk;
        if (line_cnt_q != '0) begin
          emit_c       = 1'b1;
          out_status_d = status_c;
          if (status_c != StOk) begin
            halted_d = 1'b1;
          end
          if (s3_line_ok_c) begin
            s3_total_d = s3_total_q + 16'd1;
          end
        end
      end else if (LenCmpW'(line_cnt_q) < LenCmpW'(MaxLineChars)) begin
        line_cnt_d = line_cnt_q + LineCntW'(1);
        if (line_cnt_q == LineCntW'(0)) begin
          if (s1_char_q != CharS) begin
            first_err_d = StNoS;
          end
        end else if (line_cnt_q == LineCntW'(1)) begin
          rec_type_d = s1_char_q;
        end else begin
          if (!hex_c.ok && first_err_q == StOk) begin
            first_err_d = StHex;
          end
          if (line_cnt_q == LineCntW'(2)) begin
            hi_nib_d = hex_c.value;
          end else if (line_cnt_q == LineCntW'(3)) begin
            count_d = byte_c;
            sum_d   = byte_c;
          end else if (!line_cnt_q[0]) begin
            hi_nib_d = hex_c.value;
          end else begin
            // Second digit of a pair: the byte is complete.
            sum_d = sum_q + byte_c;
            if (pair_idx_q < 8'(alen_c)) begin
              addr_acc_c = {addr_q[23:0], byte_c};
            end
            addr_d = addr_acc_c;
            if (pair_idx_q != 8'hff) begin
              pair_idx_d = pair_idx_q + 8'd1;
            end
            if (first_err_d == StOk) begin
              if (rec_type_q == TypeS3 && pair_idx_q >= 8'd4 &&
                  (9'(pair_idx_q) + 9'd1) < 9'(count_q)) begin
                emit_c     = 1'b1;
                out_kind_d = KindData;
                out_addr_d = addr_acc_c;
                out_data_d = byte_c;
                addr_d     = addr_acc_c + 32'd1;
              end else if (rec_type_q == TypeS7 && pair_idx_q == 8'd3 &&
                           count_q == 8'd5) begin
                emit_c     = 1'b1;
                out_kind_d = KindStart;
                out_addr_d = addr_acc_c;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q  <= '0;
      rec_type_q  <= 8'd0;
      count_q     <= 8'd0;
      sum_q       <= 8'd0;
      hi_nib_q    <= 4'd0;
      pair_idx_q  <= 8'd0;
      addr_q      <= 32'd0;
      first_err_q <= StOk;
      s3_total_q  <= 16'd0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      line_cnt_q  <= line_cnt_d;
      rec_type_q  <= rec_type_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      hi_nib_q    <= hi_nib_d;
      pair_idx_q  <= pair_idx_d;
      addr_q      <= addr_d;
      first_err_q <= first_err_d;
      s3_total_q  <= s3_total_d;
      halted_q    <= halted_d;
      if (emit_c) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_c) begin
      out_kind_q   <= out_kind_d;
      out_addr_q   <= out_addr_d;
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.byte_address = out_addr_q;
  assign result_o.data_byte    = out_data_q;
  assign result_o.line_status  = out_status_q;

  assign reject_c  = emit_c && out_kind_d == KindStatus && out_status_d != StOk;
  assign line_ok_c = LenCmpW'(line_cnt_q) <= LenCmpW'(MaxLineChars);

  `SRLP_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "parser left the halted state")
  `SRLP_ASSERT_SAME(a_halt_silent, halted_q, !emit_c, "result produced while halted")
  `SRLP_ASSERT_NEXT(a_bad_status_halts, reject_c, halted_q, "rejected line did not halt")
  `SRLP_ASSERT_SAME(a_line_bound, 1'b1, line_ok_c, "line character count beyond its limit")

endmodule
